[rtl/surface_command_decoder_assert.svh]
// Assertion macros used by the surface command decoder checker.
`ifndef SURFACE_COMMAND_DECODER_ASSERT_SVH
`define SURFACE_COMMAND_DECODER_ASSERT_SVH

// Clocked assertion that is not checked while reset is asserted.
`define SCD_ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is checked at every edge, reset included.
`define SCD_ASSERT_ALL(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/scd_pkg.sv]
// Package with the types, codes and pattern tables of the surface command decoder.
`timescale 1ns / 1ps

package scd_pkg;

  localparam int NUM_PAT = 8;
  localparam logic [31:0] MIN_TIME_RESET = 32'd1735689600;
  localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;
  localparam logic [7:0] CHAR_CR = 8'd13;
  localparam logic [7:0] CHAR_LF = 8'd10;
  localparam logic [7:0] CHAR_ZERO = "0";
  localparam logic [7:0] CHAR_NINE = "9";
  localparam logic [7:0] CHAR_T = "T";
  localparam logic [7:0] CHAR_DIGIT = "#";
  localparam logic [2:0] COUNT_MAX = 3'd7;

  typedef enum logic [3:0] {
    CMD_NONE     = 4'd0,
    CMD_QUERY    = 4'd1,
    CMD_TIMESYNC = 4'd2,
    CMD_STOPFIL  = 4'd3,
    CMD_STOPSYS  = 4'd4,
    CMD_TURBO    = 4'd5,
    CMD_RGA      = 4'd6,
    CMD_START    = 4'd7,
    CMD_SPEED    = 4'd8,
    CMD_INVALID  = 4'd9
  } cmd_t;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       last;
  } in_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] time_value;
    logic [13:0] speed;
  } out_t;

  // Fixed patterns, seven characters each, padded past their length.
  localparam logic [55:0] PAT_TEXT [NUM_PAT] = '{
    "?      ", "!ZFS   ", "!Z21   ", "!Z22   ",
    "!Z10   ", "!Z12   ", "!Z11   ", "!RS####"
  };
  localparam logic [2:0] PAT_LEN [NUM_PAT] = '{
    3'd1, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd7
  };
  localparam cmd_t PAT_CMD [NUM_PAT] = '{
    CMD_QUERY, CMD_STOPFIL, CMD_STOPSYS, CMD_STOPSYS,
    CMD_TURBO, CMD_RGA, CMD_START, CMD_SPEED
  };

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CHAR_ZERO) && (b <= CHAR_NINE);
  endfunction

  function automatic logic [7:0] pat_char(input logic [55:0] text, input logic [2:0] p);
    logic [2:0] idx;
    idx = 3'd6 - p;
    return text[{idx, 3'b000} +: 8];
  endfunction

endpackage

[rtl/scd_decode.sv]
// Message state, pattern matching and command decision of the surface command decoder.
`timescale 1ns / 1ps

module scd_decode (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  scd_pkg::in_t  item,
  input  logic [31:0]   min_time,
  output scd_pkg::out_t res
);

  logic [2:0]         char_count_r, char_count_nxt;
  logic [7:0]         first_char_r, first_char_nxt;
  logic [scd_pkg::NUM_PAT-1:0] alive_r, alive_nxt;
  logic [31:0]        number_acc_r, number_acc_nxt;
  logic               number_bad_r, number_bad_nxt;
  logic [13:0]        speed_acc_r, speed_acc_nxt;
  logic               crlf_pending_r, crlf_pending_nxt;
  logic               crlf_inside_r, crlf_inside_nxt;

  logic [7:0]  b;
  logic [3:0]  d;
  logic        dig;
  logic [35:0] acc_ext;
  logic [13:0] spd_ext;
  logic        found;
  logic [7:0]  pc;

  assign b   = item.byte_in;
  assign dig = scd_pkg::is_digit(b);
  assign d   = 4'(b - scd_pkg::CHAR_ZERO);
  assign acc_ext = {1'b0, number_acc_r, 3'b000} + {3'b000, number_acc_r, 1'b0} + {32'd0, d};
  assign spd_ext = {speed_acc_r[10:0], 3'b000} + {speed_acc_r[12:0], 1'b0} + {10'd0, d};

  always_comb begin
    char_count_nxt   = char_count_r;
    first_char_nxt   = first_char_r;
    alive_nxt        = alive_r;
    number_acc_nxt   = number_acc_r;
    number_bad_nxt   = number_bad_r;
    speed_acc_nxt    = speed_acc_r;
    crlf_pending_nxt = crlf_pending_r;
    crlf_inside_nxt  = crlf_inside_r;
    pc = 8'd0;
    if ((b == scd_pkg::CHAR_CR) || (b == scd_pkg::CHAR_LF)) begin
      crlf_pending_nxt = 1'b1;
    end else begin
      if (crlf_pending_r) begin
        crlf_inside_nxt  = 1'b1;
        crlf_pending_nxt = 1'b0;
      end
      if (char_count_r == 3'd0) begin
        first_char_nxt = b;
      end else if (!number_bad_r) begin
        if (!dig || (acc_ext[35:32] != 4'd0)) begin
          number_bad_nxt = 1'b1;
        end else begin
          number_acc_nxt = acc_ext[31:0];
        end
      end
      if ((char_count_r >= 3'd3) && (char_count_r <= 3'd6) && dig) begin
        speed_acc_nxt = spd_ext;
      end
      for (int k = 0; k < scd_pkg::NUM_PAT; k++) begin
        if (char_count_r >= scd_pkg::PAT_LEN[k]) begin
          alive_nxt[k] = 1'b0;
        end else begin
          pc = scd_pkg::pat_char(scd_pkg::PAT_TEXT[k], char_count_r);
          if (pc == scd_pkg::CHAR_DIGIT) begin
            if (!dig) begin
              alive_nxt[k] = 1'b0;
            end
          end else if (b != pc) begin
            alive_nxt[k] = 1'b0;
          end
        end
      end
      if (char_count_r != scd_pkg::COUNT_MAX) begin
        char_count_nxt = char_count_r + 3'd1;
      end
    end
  end

  always_comb begin
    res.cmd        = scd_pkg::CMD_INVALID;
    res.time_value = 32'd0;
    res.speed      = 14'd0;
    found          = 1'b0;
    if (char_count_nxt == 3'd0) begin
      res.cmd = scd_pkg::CMD_NONE;
    end else if (crlf_inside_nxt) begin
      res.cmd = scd_pkg::CMD_INVALID;
    end else if (first_char_nxt == scd_pkg::CHAR_T) begin
      if ((char_count_nxt >= 3'd2) && !number_bad_nxt && (number_acc_nxt > min_time) &&
          (number_acc_nxt != scd_pkg::TIME_MAX)) begin
        res.cmd        = scd_pkg::CMD_TIMESYNC;
        res.time_value = number_acc_nxt;
      end
    end else begin
      for (int k = 0; k < scd_pkg::NUM_PAT; k++) begin
        if (!found && alive_nxt[k] && (char_count_nxt == scd_pkg::PAT_LEN[k])) begin
          found   = 1'b1;
          res.cmd = scd_pkg::PAT_CMD[k];
          if (scd_pkg::PAT_CMD[k] == scd_pkg::CMD_SPEED) begin
            res.speed = speed_acc_nxt;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (en && item.last)) begin
      char_count_r   <= 3'd0;
      first_char_r   <= 8'd0;
      alive_r        <= '1;
      number_acc_r   <= 32'd0;
      number_bad_r   <= 1'b0;
      speed_acc_r    <= 14'd0;
      crlf_pending_r <= 1'b0;
      crlf_inside_r  <= 1'b0;
    end else if (en) begin
      char_count_r   <= char_count_nxt;
      first_char_r   <= first_char_nxt;
      alive_r        <= alive_nxt;
      number_acc_r   <= number_acc_nxt;
      number_bad_r   <= number_bad_nxt;
      speed_acc_r    <= speed_acc_nxt;
      crlf_pending_r <= crlf_pending_nxt;
      crlf_inside_r  <= crlf_inside_nxt;
    end
  end

endmodule

[rtl/surface_command_decoder.sv]
// Top level of the surface command decoder: request registers, handshakes and min_time.
`timescale 1ns / 1ps

// The decoder takes one message byte per cycle while its output is not stalled, and
// gives one decoded command on the request that carries the last flag. Each byte
// passes an input register and then the decode logic into the result register; a
// stalled output holds the result back. Bytes are accepted whenever the input register
// is empty or moving on; the rate is set by the single decode stage that updates the
// message state and the result register together. A stalled result holds both stages
// in place. Write min_time only while no message is in flight.
module surface_command_decoder (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  scd_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output scd_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic [31:0]   cfg_wdata
);

  logic          s1_valid_r;
  scd_pkg::in_t  s1_data_r;
  logic          out_valid_r, out_valid_nxt;
  scd_pkg::out_t out_data_r;
  scd_pkg::out_t res;
  logic [31:0]   min_time_r;
  logic          adv;
  logic          s1_fire;

  assign adv      = !out_valid_r || out_ready;
  assign s1_fire  = s1_valid_r && adv;
  assign in_ready = !s1_valid_r || adv;

  scd_decode u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (s1_fire),
    .item     (s1_data_r),
    .min_time (min_time_r),
    .res      (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = s1_valid_r && s1_data_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      min_time_r  <= scd_pkg::MIN_TIME_RESET;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_valid && in_ready) begin
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        min_time_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
    if (s1_fire && s1_data_r.last) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[rtl/scd_checker.sv]
// Port-level checker for the surface command decoder and its bind.
`timescale 1ns / 1ps
`include "surface_command_decoder_assert.svh"

module scd_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          out_valid,
  input logic          out_ready,
  input scd_pkg::out_t out_data
);

  logic stalled;
  logic time_clean;
  logic speed_clean;

  assign stalled     = out_valid && !out_ready;
  assign time_clean  = (out_data.cmd == scd_pkg::CMD_TIMESYNC) || (out_data.time_value == 32'd0);
  assign speed_clean = (out_data.cmd == scd_pkg::CMD_SPEED) || (out_data.speed == 14'd0);

  `SCD_ASSERT_RST(a_hold, clk, rst_n, stalled |=> out_valid && $stable(out_data), "stall broken")
  `SCD_ASSERT_RST(a_time_only_sync, clk, rst_n, out_valid |-> time_clean, "stray time value")
  `SCD_ASSERT_RST(a_speed_only_cmd, clk, rst_n, out_valid |-> speed_clean, "stray speed value")
  `SCD_ASSERT_ALL(a_reset_empty, clk, !rst_n |=> !out_valid, "result offered right after reset")

endmodule

bind surface_command_decoder scd_checker u_scd_checker (.*);

[verif/surface_command_decoder_tb.sv]
// Self-checking testbench for the surface command decoder with a bytewise decode predictor.
`timescale 1ns / 1ps

module surface_command_decoder_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam logic [31:0] RESET_MIN_TIME = 32'd1735689600;

  typedef struct {
    logic [127:0]  text;
    bit            typed;
    scd_pkg::out_t want;
  } dir_row_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  scd_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b1;
  scd_pkg::out_t out_data;
  logic cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;

  surface_command_decoder u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  string pattern_text [8] = '{"?", "!ZFS", "!Z21", "!Z22", "!Z10", "!Z12", "!Z11",
                              "!RS####"};
  scd_pkg::cmd_t pattern_cmd [8] = '{
    scd_pkg::CMD_QUERY, scd_pkg::CMD_STOPFIL, scd_pkg::CMD_STOPSYS, scd_pkg::CMD_STOPSYS,
    scd_pkg::CMD_TURBO, scd_pkg::CMD_RGA, scd_pkg::CMD_START, scd_pkg::CMD_SPEED
  };

  logic [31:0] dec_min_time = RESET_MIN_TIME;
  logic [2:0]  dec_count = '0;
  logic [7:0]  dec_first = '0;
  logic [7:0]  dec_alive = 8'hFF;
  logic [31:0] dec_acc = '0;
  logic        dec_bad = 1'b0;
  logic [13:0] dec_speed = '0;
  logic        dec_crlf_pend = 1'b0;
  logic        dec_crlf_seen = 1'b0;

  scd_pkg::out_t pending_cmds [$];
  logic [7:0] msg_bytes [$];
  dir_row_t dir_rows [$];

  int tx_idle_pct = 20;
  int rx_idle_pct = 20;
  bit calm = 1'b0;
  int rx_hold = 0;
  int cycle_count = 0;
  int mismatch_count = 0;

  task automatic decode_byte(input logic [7:0] b, input logic lst, output scd_pkg::out_t res);
    logic [7:0] d;
    logic [7:0] pc;
    logic [2:0] p;
    logic dig;
    logic hit;
    logic found;
    res = '0;
    if (b == 8'd13 || b == 8'd10) begin
      dec_crlf_pend = 1'b1;
    end else begin
      if (dec_crlf_pend) begin
        dec_crlf_seen = 1'b1;
        dec_crlf_pend = 1'b0;
      end
      p = dec_count;
      d = b - 8'd48;
      dig = (b >= 8'd48) && (b <= 8'd57);
      if (p == 3'd0) begin
        dec_first = b;
      end else if (!dec_bad) begin
        if (!dig || dec_acc > (32'hFFFF_FFFF - {24'd0, d}) / 32'd10) begin
          dec_bad = 1'b1;
        end else begin
          dec_acc = dec_acc * 32'd10 + {24'd0, d};
        end
      end
      if (p >= 3'd3 && p <= 3'd6 && dig) begin
        dec_speed = dec_speed * 14'd10 + {6'd0, d};
      end
      for (int k = 0; k < 8; k++) begin
        if (p >= pattern_text[k].len()) begin
          hit = 1'b0;
        end else begin
          pc = pattern_text[k].getc(p);
          hit = (pc == "#") ? dig : (b == pc);
        end
        if (!hit) begin
          dec_alive[k] = 1'b0;
        end
      end
      if (dec_count != 3'd7) begin
        dec_count = dec_count + 3'd1;
      end
    end
    if (lst) begin
      res.cmd = scd_pkg::CMD_INVALID;
      if (dec_count == 3'd0) begin
        res.cmd = scd_pkg::CMD_NONE;
      end else if (!dec_crlf_seen) begin
        if (dec_first == "T") begin
          if (dec_count >= 3'd2 && !dec_bad && dec_acc > dec_min_time &&
              dec_acc != 32'hFFFF_FFFF) begin
            res.cmd = scd_pkg::CMD_TIMESYNC;
            res.time_value = dec_acc;
          end
        end else begin
          found = 1'b0;
          for (int k = 0; k < 8; k++) begin
            if (!found && dec_alive[k] && dec_count == pattern_text[k].len()) begin
              found = 1'b1;
              res.cmd = pattern_cmd[k];
              if (res.cmd == scd_pkg::CMD_SPEED) begin
                res.speed = dec_speed;
              end
            end
          end
        end
      end
      dec_count = '0;
      dec_first = '0;
      dec_alive = 8'hFF;
      dec_acc = '0;
      dec_bad = 1'b0;
      dec_speed = '0;
      dec_crlf_pend = 1'b0;
      dec_crlf_seen = 1'b0;
    end
  endtask

  function automatic void add_row(logic [127:0] text, bit typed, scd_pkg::cmd_t cmd,
                                  logic [31:0] tv, logic [13:0] sp);
    dir_row_t r;
    r.text = text;
    r.typed = typed;
    r.want.cmd = cmd;
    r.want.time_value = tv;
    r.want.speed = sp;
    dir_rows.push_back(r);
  endfunction

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      msg_bytes.push_back(s.getc(i));
    end
  endtask

  task automatic add_wellformed();
    longint unsigned v;
    case ($urandom_range(0, 4))
      0: msg_bytes.push_back("?");
      1: push_text(pattern_text[$urandom_range(1, 6)]);
      2: begin
        push_text("!RS");
        repeat (4) msg_bytes.push_back(8'($urandom_range(48, 57)));
      end
      default: begin
        case ($urandom_range(0, 4))
          0: begin
            v = {32'd0, dec_min_time} + 64'($urandom_range(0, 4));
            v = (v < 2) ? 64'd0 : v - 64'd2;
          end
          1: v = 64'($urandom);
          2: v = 64'd4294967290 + 64'($urandom_range(0, 10));
          3: v = {32'($urandom_range(1, 20)), 32'($urandom)};
          default: v = 64'($urandom_range(0, 99));
        endcase
        msg_bytes.push_back("T");
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 4)) msg_bytes.push_back("0");
        end
        push_text($sformatf("%0d", v));
      end
    endcase
  endtask

  task automatic make_random_message();
    int kind;
    int pos;
    msg_bytes.delete();
    kind = $urandom_range(0, 99);
    if (kind < 62) begin
      add_wellformed();
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) msg_bytes.push_back($urandom_range(0, 1) ? 8'd13 : 8'd10);
      end
    end else if (kind < 82) begin
      add_wellformed();
      pos = $urandom_range(0, msg_bytes.size() - 1);
      case ($urandom_range(0, 3))
        0: msg_bytes[pos] = 8'($urandom_range(0, 255));
        1: if (msg_bytes.size() > 1) msg_bytes.delete(pos);
        2: msg_bytes.insert(pos, 8'($urandom_range(32, 126)));
        default: msg_bytes.insert(pos, $urandom_range(0, 1) ? 8'd13 : 8'd10);
      endcase
    end else if (kind < 88) begin
      repeat ($urandom_range(1, 3)) msg_bytes.push_back($urandom_range(0, 1) ? 8'd13 : 8'd10);
    end else begin
      repeat ($urandom_range(1, 12)) msg_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic lst, input bit typed,
                           input scd_pkg::out_t typed_res);
    int gap;
    scd_pkg::out_t res;
    if (!calm && $urandom_range(0, 99) < tx_idle_pct) begin
      gap = $urandom_range(1, 9);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{byte_in: b, last: lst};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    decode_byte(b, lst, res);
    if (lst) begin
      pending_cmds.push_back(typed ? typed_res : res);
    end
  endtask

  task automatic send_message(input bit typed, input scd_pkg::out_t typed_res);
    for (int i = 0; i < msg_bytes.size(); i++) begin
      send_byte(msg_bytes[i], i == msg_bytes.size() - 1, typed, typed_res);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
    end else if (!calm && $urandom_range(0, 99) < rx_idle_pct) begin
      rx_hold <= $urandom_range(0, 8);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    scd_pkg::out_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("surface_command_decoder verification failed");
      $finish;
    end else if (rst_n && out_valid && out_ready) begin
      if (pending_cmds.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected result: cmd %0d time %0d speed %0d",
                   out_data.cmd, out_data.time_value, out_data.speed);
        end
      end else begin
        want = pending_cmds.pop_front();
        if (out_data.cmd !== want.cmd || out_data.time_value !== want.time_value ||
            out_data.speed !== want.speed) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: expected cmd %0d time %0d speed %0d, %s %0d time %0d speed %0d",
                     want.cmd, want.time_value, want.speed, "got cmd",
                     out_data.cmd, out_data.time_value, out_data.speed);
          end
        end
      end
    end
  end

  initial begin
    int tx_pct [6];
    int rx_pct [6];
    int n;
    int sent;
    logic [31:0] cfg_value;
    tx_pct = '{20, 0, 35, 10, 50, 0};
    rx_pct = '{25, 40, 0, 10, 50, 0};
    add_row("?", 1, scd_pkg::CMD_QUERY, 0, 0);
    add_row("!ZFS", 1, scd_pkg::CMD_STOPFIL, 0, 0);
    add_row("!Z21", 1, scd_pkg::CMD_STOPSYS, 0, 0);
    add_row("!Z22", 1, scd_pkg::CMD_STOPSYS, 0, 0);
    add_row("!Z10", 1, scd_pkg::CMD_TURBO, 0, 0);
    add_row("!Z12", 1, scd_pkg::CMD_RGA, 0, 0);
    add_row("!Z11", 1, scd_pkg::CMD_START, 0, 0);
    add_row("!RS0000", 1, scd_pkg::CMD_SPEED, 0, 0);
    add_row("!RS9999", 1, scd_pkg::CMD_SPEED, 0, 9999);
    add_row("T4294967294", 1, scd_pkg::CMD_TIMESYNC, 32'd4294967294, 0);
    add_row("T4294967295", 1, scd_pkg::CMD_INVALID, 0, 0);
    add_row("T4294967296", 1, scd_pkg::CMD_INVALID, 0, 0);
    add_row("T1735689600", 1, scd_pkg::CMD_INVALID, 0, 0);
    add_row("T1735689601", 1, scd_pkg::CMD_TIMESYNC, 32'd1735689601, 0);
    add_row("T0", 1, scd_pkg::CMD_INVALID, 0, 0);
    add_row("T", 1, scd_pkg::CMD_INVALID, 0, 0);
    add_row({8'd13, 8'd10}, 1, scd_pkg::CMD_NONE, 0, 0);
    add_row(8'h00, 1, scd_pkg::CMD_INVALID, 0, 0);
    add_row(8'hFF, 1, scd_pkg::CMD_INVALID, 0, 0);
    add_row({"?", 8'd13, "?"}, 1, scd_pkg::CMD_INVALID, 0, 0);
    add_row({"?", 8'd13, 8'd10}, 0, scd_pkg::CMD_NONE, 0, 0);
    add_row("!RS12345", 0, scd_pkg::CMD_NONE, 0, 0);
    add_row("T12a", 0, scd_pkg::CMD_NONE, 0, 0);
    add_row("T0001735689601", 0, scd_pkg::CMD_NONE, 0, 0);
    add_row("!Z2", 0, scd_pkg::CMD_NONE, 0, 0);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[r]) begin
      n = 16;
      while (n > 1 && dir_rows[r].text[8*n-1 -: 8] == 8'd0) n--;
      msg_bytes.delete();
      for (int i = n - 1; i >= 0; i--) begin
        msg_bytes.push_back(dir_rows[r].text[8*i +: 8]);
      end
      send_message(dir_rows[r].typed, dir_rows[r].want);
    end
    settle();

    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        case (ph)
          1: cfg_value = 32'd0;
          2: cfg_value = 32'hFFFF_FFFF;
          3: cfg_value = 32'hFFFF_FFFE;
          4: cfg_value = $urandom;
          default: cfg_value = RESET_MIN_TIME;
        endcase
        cfg_we <= 1'b1;
        cfg_wdata <= cfg_value;
        @(posedge clk);
        cfg_we <= 1'b0;
        dec_min_time = cfg_value;
      end
      tx_idle_pct = tx_pct[ph];
      rx_idle_pct = rx_pct[ph];
      calm = (ph == 5);
      sent = 0;
      while (sent < 270) begin
        make_random_message();
        sent += msg_bytes.size();
        send_message(1'b0, '0);
      end
      settle();
    end

    if (mismatch_count == 0 && pending_cmds.size() == 0) begin
      $display("surface_command_decoder verification clean");
    end else begin
      $display("surface_command_decoder verification failed");
    end
    $finish;
  end

endmodule
